// File: rtl/core/ett_pkg.sv
// Shared types and constants for the Euler totient trial-division block.
// Holds the controller state encoding and the controller/datapath command and status structs.
// Depends on nothing; the controller, the datapath and the top level import it.
package ett_pkg;

  // Default operand width of the block.
  localparam int unsigned ETT_NUM_WIDTH = 32;

  // Trial division starts at the smallest prime.
  localparam int unsigned ETT_FIRST_DIVISOR = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP_START,
    ST_TOP_WAIT,
    ST_FACT_MUL,
    ST_INNER_START,
    ST_INNER_WAIT,
    ST_FIN_MUL,
    ST_DONE
  } ctrl_state_t;

  // Which operand the accumulator is multiplied by.
  typedef enum logic [1:0] {
    MUL_D_MINUS1,
    MUL_D,
    MUL_N_MINUS1
  } mul_sel_t;

  typedef struct packed {
    logic     load;       // Take a new number and restart the factorization.
    logic     div_start;  // Divide the cofactor by the current divisor.
    logic     mul_start;  // Multiply the accumulator by the selected operand.
    mul_sel_t mul_sel;
    logic     n_take_q;   // Replace the cofactor by the last quotient.
    logic     d_inc;      // Move on to the next candidate divisor.
    logic     out_load;   // Copy the accumulator into the output register.
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;  // Quotient and remainder are valid.
    logic mul_done;  // Product is final; the accumulator takes it on this clock edge.
    logic q_lt_d;    // Quotient is below the divisor: trial division is over.
    logic r_zero;    // Divisor divides the cofactor.
    logic n_gt1;     // Cofactor is above one.
  } dp_sts_t;

endpackage

// File: rtl/core/euler_totient_trial_division.sv
// Euler totient by trial division: one number in, phi(number) out.
// Slave channel in_*: one transaction carries the number in in_tdata; bits above
// NUM_WIDTH are ignored. Master channel out_*: one transaction carries the totient.
// Inputs zero and one both give a totient of one. No state is kept between items.
// The block works on one item at a time. Each candidate divisor costs one division
// on the shared bit-serial divider, and the candidates run from 2 up to D, the
// largest candidate divisor tried (about the square root of the largest remaining
// cofactor). Each prime factor found, counted with multiplicity, adds one more
// division and one multiplication, and a leftover prime adds one multiplication.
// At 32 bits the longest run is for a prime just below 2**32.
// The result sits in an output register. While it waits for out_tready the block
// already accepts and works on the next number; it only holds in its last step when
// the previous result has still not been taken.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_tvalid;
// a number in flight is lost. No clearing pass is needed after reset.
// Depends on ett_pkg, ett_ctrl, ett_datapath, ett_divider and ett_multiplier.
module euler_totient_trial_division #(
  parameter int unsigned NUM_WIDTH = ett_pkg::ETT_NUM_WIDTH,
  parameter int unsigned TDATA_W   = ((NUM_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [NUM_WIDTH-1:0] number, rest padding
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // [NUM_WIDTH-1:0] totient, rest zero
);

  import ett_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [NUM_WIDTH-1:0] totient;

  // The controller owns the handshakes and sequencing; the datapath only
  // follows its commands and reports back through the status struct.
  ett_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ett_datapath #(.W(NUM_WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .number  (in_tdata[NUM_WIDTH-1:0]),
    .sts     (sts),
    .totient (totient)
  );

  // Padding bits above the totient are driven to zero.
  assign out_tdata = TDATA_W'(totient);

endmodule

// File: rtl/core/ett_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Used by the datapath for both the loop bound test and the divisibility test.
// Depends on nothing outside this file.
module ett_divider #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // The top bit of the trial difference is set when the divisor does not fit.
      rem_nxt = trial[W] ? shifted[W-1:0] : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ~trial[W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/core/ett_multiplier.sv
// Shift-and-add multiplier keeping the low W bits of the product.
// Stops as soon as no multiplier bits are left. Depends on nothing outside this file.
module ett_multiplier #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] mcand,
  input  logic [W-1:0] mplier,
  output logic         done,
  output logic [W-1:0] product
);

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [W-1:0] prod_r, prod_nxt;
  logic [W-1:0] mcand_r, mcand_nxt;
  logic [W-1:0] mplr_r, mplr_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    if (start) begin
      busy_nxt  = 1'b1;
      prod_nxt  = '0;
      mcand_nxt = mcand;
      mplr_nxt  = mplier;
    end else if (busy_r) begin
      if (mplr_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (mplr_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt = {mcand_r[W-2:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

// File: rtl/core/ett_datapath.sv
// Datapath of the totient block: cofactor, divisor and accumulator registers,
// the shared divider, the multiplier and the output data register.
// Depends on ett_pkg, ett_divider and ett_multiplier.
module ett_datapath #(
  parameter int unsigned W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ett_pkg::dp_cmd_t cmd,
  input  logic [W-1:0]     number,
  output ett_pkg::dp_sts_t sts,
  output logic [W-1:0]     totient
);

  import ett_pkg::*;

  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] out_r, out_nxt;
  logic [W-1:0] mul_op;
  logic [W-1:0] quotient;
  logic [W-1:0] remainder;
  logic [W-1:0] product;
  logic         div_done;
  logic         mul_done;

  ett_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_D_MINUS1: mul_op = d_r - 1'b1;
      MUL_D:        mul_op = d_r;
      MUL_N_MINUS1: mul_op = n_r - 1'b1;
      default:      mul_op = d_r;
    endcase
  end

  ett_multiplier #(.W(W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .mcand   (acc_r),
    .mplier  (mul_op),
    .done    (mul_done),
    .product (product)
  );

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    acc_nxt = acc_r;
    out_nxt = out_r;
    if (cmd.load) begin
      n_nxt   = number;
      d_nxt   = W'(ETT_FIRST_DIVISOR);
      acc_nxt = W'(1);
    end else begin
      if (cmd.n_take_q) n_nxt = quotient;
      if (cmd.d_inc)    d_nxt = d_r + 1'b1;
      if (mul_done)     acc_nxt = product;
    end
    if (cmd.out_load) out_nxt = acc_r;
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign sts.div_done = div_done;
  assign sts.mul_done = mul_done;
  assign sts.q_lt_d   = quotient < d_r;
  assign sts.r_zero   = remainder == '0;
  assign sts.n_gt1    = n_r > W'(1);
  assign totient      = out_r;

endmodule

// File: rtl/core/ett_ctrl.sv
// Controller state machine of the totient block: sequences divisions and
// multiplications and runs the input and output handshakes.
// Depends on ett_pkg.
module ett_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  ett_pkg::dp_sts_t sts,
  output ett_pkg::dp_cmd_t cmd
);

  import ett_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:        if (in_tvalid) state_nxt = ST_TOP_START;
      ST_TOP_START:   state_nxt = ST_TOP_WAIT;
      ST_TOP_WAIT: begin
        if (sts.div_done) begin
          if (sts.q_lt_d) begin
            state_nxt = sts.n_gt1 ? ST_FIN_MUL : ST_DONE;
          end else if (sts.r_zero) begin
            state_nxt = ST_FACT_MUL;
          end else begin
            state_nxt = ST_TOP_START;
          end
        end
      end
      ST_FACT_MUL:    if (sts.mul_done) state_nxt = ST_INNER_START;
      ST_INNER_START: state_nxt = ST_INNER_WAIT;
      ST_INNER_WAIT: begin
        if (sts.div_done) begin
          state_nxt = sts.r_zero ? ST_FACT_MUL : ST_TOP_START;
        end
      end
      ST_FIN_MUL:     if (sts.mul_done) state_nxt = ST_DONE;
      ST_DONE:        if (out_free) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_D;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_TOP_START, ST_INNER_START: cmd.div_start = 1'b1;
      ST_TOP_WAIT: begin
        if (sts.div_done) begin
          if (sts.q_lt_d) begin
            cmd.mul_start = sts.n_gt1;
            cmd.mul_sel   = MUL_N_MINUS1;
          end else if (sts.r_zero) begin
            cmd.n_take_q  = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_D_MINUS1;
          end else begin
            cmd.d_inc = 1'b1;
          end
        end
      end
      ST_INNER_WAIT: begin
        if (sts.div_done) begin
          if (sts.r_zero) begin
            cmd.n_take_q  = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_D;
          end else begin
            cmd.d_inc = 1'b1;
          end
        end
      end
      ST_DONE:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
